@@ src/multi_slot_repeating_run_timer_macros.svh @@
// Assertion macros for the multi-slot run timer.
`ifndef MULTI_SLOT_REPEATING_RUN_TIMER_MACROS_SVH
`define MULTI_SLOT_REPEATING_RUN_TIMER_MACROS_SVH
`ifndef SYNTH
`define MSRT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("msrt assertion failed");
`define MSRT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("msrt assertion failed");
`else
`define MSRT_ASSERT(lbl, clk, rst_n, prop)
`define MSRT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ src/msrt_pkg.sv @@
package msrt_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [1:0] OP_SCHED  = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [2:0] ST_SCHED = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_PROG  = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_ACK   = 3'd4;

    localparam int FL_REMOVE = 0;
    localparam int FL_NOTIFY = 1;
    localparam int FL_COLOUR = 2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] obj_id;
        logic [31:0] elapsed_us;
        logic [31:0] first_wait_us;
        logic [31:0] run_length_us;
        logic [31:0] wait_between_runs_us;
        logic [7:0]  run_count;
        logic        remove_object_at_end;
        logic        notify_valid;
        logic [7:0]  notify_id;
        logic        colour_entry;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [15:0] target_object;
        logic [31:0] run_elapsed_us;
        logic [31:0] remaining_at_run_start_us;
        logic        remove_object;
        logic        notify;
        logic [7:0]  notify_code;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [15:0] obj;
        logic [31:0] wait_left;
        logic [31:0] run_left;
        logic [31:0] run_length;
        logic [31:0] gap_length;
        logic [7:0]  runs_left;
        logic [2:0]  flags;
        logic [7:0]  nid;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [32:0] rem;
    } t_div_rsp;

endpackage

@@ src/msrt_ram.sv @@
module msrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/msrt_div.sv @@
module msrt_div import msrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [32:0] i_divisor,
    output t_div_rsp    o_rsp
);
    // restoring divider, one quotient bit per cycle
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_q;
    logic [32:0] r_d;
    logic [33:0] shifted;
    logic [33:0] diff;

    assign shifted = {r_rem, r_q[31]};
    assign diff    = shifted - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            if (!diff[33]) begin
                r_rem <= diff[32:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= shifted[32:0];
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;
endmodule

@@ src/multi_slot_repeating_run_timer.sv @@
// Multi-slot repeating run timer.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one command
// transaction at a time: schedule an entry, tick elapsed time, or cancel the
// colour entries of an object. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns one or more result transactions per command; the final
// one has last set.
// A command is taken only when the block is idle. Schedule and cancel walk the
// slot table from slot 0 upward. A tick walks every slot from the top down; a
// used slot is read, updated and written back unless it finished, and repeat
// catch-up needs the shared serial divider, which holds the walk until done.
// Slot contents live in one RAM (registered read); the walk through it and
// the single divider set the cycle count.
// Reset: all slots free, output empty; no clearing pass is needed.
// Stall: results queue through a one-entry hold buffer and the output
// register; when the receiver stalls the walk waits on the next result.
module multi_slot_repeating_run_timer import msrt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);
`include "multi_slot_repeating_run_timer_macros.svh"

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] IDX_MAX = IW'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_SCHED, S_TSCAN, S_TRD, S_TWAIT, S_TRUN, S_TCATCH,
        S_TDIV, S_TREM, S_TWB, S_TNEXT, S_CSCAN, S_CRD, S_EMIT, S_FIN
    } t_state;

    // control
    t_state           r_state, n_state, r_after, n_after;
    logic [SLOTS-1:0] r_used, n_used;
    logic             r_out_valid, n_out_valid;
    logic             r_have_pend, n_have_pend;
    // payload
    t_in              r_in, n_in;
    logic [IW-1:0]    r_idx, n_idx;
    t_slot            r_slot, n_slot;
    logic [31:0]      r_e, n_e;
    logic [31:0]      r_start, n_start;
    logic [31:0]      r_x, n_x;
    logic [32:0]      r_p, n_p;
    logic [32:0]      r_xr, n_xr;
    t_out             r_new, n_new, r_pend, n_pend, r_out, n_out;

    logic             ram_we;
    t_slot            ram_wdata;
    logic [SLOT_W-1:0] ram_rdata_bits;
    t_slot            ram_rdata;
    logic             div_start;
    t_div_rsp         div_rsp;
    logic             out_free;

    function automatic t_out mk_res(input logic [2:0] st, input logic [3:0] sl,
                                    input logic [15:0] obj, input logic [31:0] ran,
                                    input logic [31:0] rem, input logic rm,
                                    input logic nt, input logic [7:0] code);
        t_out r;
        r.status                    = st;
        r.slot                      = sl;
        r.target_object             = obj;
        r.run_elapsed_us            = ran;
        r.remaining_at_run_start_us = rem;
        r.remove_object             = rm;
        r.notify                    = nt;
        r.notify_code               = code;
        r.last                      = 1'b0;
        return r;
    endfunction

    msrt_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata_bits)
    );
    assign ram_rdata = t_slot'(ram_rdata_bits);

    msrt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_x - 32'd1),
        .i_divisor  (r_p),
        .o_rsp      (div_rsp)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        logic [3:0] sl;
        logic       nt;
        n_state     = r_state;
        n_after     = r_after;
        n_used      = r_used;
        n_have_pend = r_have_pend;
        n_in        = r_in;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_e         = r_e;
        n_start     = r_start;
        n_x         = r_x;
        n_p         = r_p;
        n_xr        = r_xr;
        n_new       = r_new;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_wdata   = r_slot;
        div_start   = 1'b0;
        sl          = 4'(r_idx);
        nt          = r_slot.flags[FL_NOTIFY];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_in.op)
                    OP_SCHED: begin
                        n_idx   = '0;
                        n_state = S_SCHED;
                    end
                    OP_TICK: begin
                        n_idx   = IDX_MAX;
                        n_state = S_TSCAN;
                    end
                    OP_CANCEL: begin
                        n_idx   = '0;
                        n_state = S_CSCAN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            // lowest free slot takes the new entry
            S_SCHED: begin
                if (!r_used[r_idx]) begin
                    ram_we               = 1'b1;
                    ram_wdata.obj        = r_in.obj_id;
                    ram_wdata.wait_left  = r_in.first_wait_us;
                    ram_wdata.run_left   = r_in.run_length_us;
                    ram_wdata.run_length = r_in.run_length_us;
                    ram_wdata.gap_length = r_in.wait_between_runs_us;
                    ram_wdata.runs_left  = r_in.run_count;
                    ram_wdata.flags      = {r_in.colour_entry, r_in.notify_valid,
                                            r_in.remove_object_at_end};
                    ram_wdata.nid        = r_in.notify_id;
                    n_used[r_idx]        = 1'b1;
                    n_pend      = mk_res(ST_SCHED, sl, r_in.obj_id, '0, '0,
                                         1'b0, 1'b0, '0);
                    n_have_pend = 1'b1;
                    n_state     = S_FIN;
                end else if (r_idx == IDX_MAX) begin
                    n_pend      = mk_res(ST_FULL, '0, r_in.obj_id, '0, '0,
                                         1'b0, 1'b0, '0);
                    n_have_pend = 1'b1;
                    n_state     = S_FIN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_TSCAN: begin
                if (r_used[r_idx]) begin
                    n_state = S_TRD;
                end else if (r_idx == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx - IW'(1);
                end
            end
            S_TRD: begin
                n_slot  = ram_rdata;
                n_e     = r_in.elapsed_us;
                n_state = S_TWAIT;
            end
            // use up the wait first
            S_TWAIT: begin
                if (r_slot.wait_left != '0) begin
                    if (r_e > r_slot.wait_left) begin
                        n_e              = r_e - r_slot.wait_left;
                        n_slot.wait_left = '0;
                        n_state          = S_TRUN;
                    end else begin
                        n_slot.wait_left = r_slot.wait_left - r_e;
                        n_state          = S_TWB;
                    end
                end else begin
                    n_state = S_TRUN;
                end
            end
            S_TRUN: begin
                if (r_slot.run_left >= r_e) begin
                    n_slot.run_left = r_slot.run_left - r_e;
                    if (r_e != '0) begin
                        n_new   = mk_res(ST_PROG, sl, r_slot.obj, r_e,
                                         r_slot.run_left, 1'b0, 1'b0, '0);
                        n_after = S_TWB;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_TWB;
                    end
                end else begin
                    n_start = r_slot.run_left;
                    n_x     = r_e - r_slot.run_left;
                    n_p     = {1'b0, r_slot.gap_length} + {1'b0, r_slot.run_length};
                    n_state = S_TCATCH;
                end
            end
            // run overrun: finish or catch up over further gap+run periods
            S_TCATCH: begin
                if (r_slot.runs_left == 8'd1) begin
                    n_used[r_idx] = 1'b0;
                    n_new   = mk_res(ST_FIN, sl, r_slot.obj, r_start, r_start,
                                     r_slot.flags[FL_REMOVE], nt,
                                     nt ? r_slot.nid : 8'd0);
                    n_after = S_TNEXT;
                    n_state = S_EMIT;
                end else if (r_p == '0) begin
                    if (r_slot.runs_left != '0) begin
                        n_used[r_idx] = 1'b0;
                        n_new   = mk_res(ST_FIN, sl, r_slot.obj, r_start, r_start,
                                         r_slot.flags[FL_REMOVE], nt,
                                         nt ? r_slot.nid : 8'd0);
                        n_after = S_TNEXT;
                        n_state = S_EMIT;
                    end else begin
                        n_slot.wait_left = '0;
                        n_slot.run_left  = '0;
                        if (r_start != '0) begin
                            n_new   = mk_res(ST_PROG, sl, r_slot.obj, r_start,
                                             r_start, 1'b0, 1'b0, '0);
                            n_after = S_TWB;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_TWB;
                        end
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = S_TDIV;
                end
            end
            // quotient = whole periods skipped, remainder+1 = time into next
            S_TDIV: begin
                if (div_rsp.done) begin
                    if (r_slot.runs_left != '0 &&
                        div_rsp.quot >= (32'(r_slot.runs_left) - 32'd1)) begin
                        n_used[r_idx] = 1'b0;
                        n_new   = mk_res(ST_FIN, sl, r_slot.obj, r_start, r_start,
                                         r_slot.flags[FL_REMOVE], nt,
                                         nt ? r_slot.nid : 8'd0);
                        n_after = S_TNEXT;
                        n_state = S_EMIT;
                    end else begin
                        if (r_slot.runs_left != '0) begin
                            n_slot.runs_left = r_slot.runs_left -
                                               div_rsp.quot[7:0] - 8'd1;
                        end
                        n_xr    = div_rsp.rem + 33'd1;
                        n_state = S_TREM;
                    end
                end
            end
            S_TREM: begin
                if ({1'b0, r_slot.gap_length} >= r_xr) begin
                    n_slot.wait_left = 32'({1'b0, r_slot.gap_length} - r_xr);
                    n_slot.run_left  = r_slot.run_length;
                end else begin
                    n_slot.wait_left = '0;
                    n_slot.run_left  = 32'(r_p - r_xr);
                end
                if (r_start != '0) begin
                    n_new   = mk_res(ST_PROG, sl, r_slot.obj, r_start, r_start,
                                     1'b0, 1'b0, '0);
                    n_after = S_TWB;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_TWB;
                end
            end
            S_TWB: begin
                ram_we  = 1'b1;
                n_state = S_TNEXT;
            end
            S_TNEXT: begin
                if (r_idx == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx - IW'(1);
                    n_state = S_TSCAN;
                end
            end
            S_CSCAN: begin
                if (r_used[r_idx]) begin
                    n_state = S_CRD;
                end else if (r_idx == IDX_MAX) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_CRD: begin
                if (ram_rdata.obj == r_in.obj_id && ram_rdata.flags[FL_COLOUR]) begin
                    n_used[r_idx] = 1'b0;
                end
                if (r_idx == IDX_MAX) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_CSCAN;
                end
            end
            // hold one result back so the final one can carry last
            S_EMIT: begin
                if (!r_have_pend) begin
                    n_pend      = r_new;
                    n_have_pend = 1'b1;
                    n_state     = r_after;
                end else if (out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_pend      = r_new;
                    n_state     = r_after;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    if (r_have_pend) begin
                        n_out = r_pend;
                    end else begin
                        n_out = mk_res(ST_ACK, '0,
                                       (r_in.op == OP_CANCEL) ? r_in.obj_id : 16'd0,
                                       '0, '0, 1'b0, 1'b0, '0);
                    end
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_have_pend = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_have_pend <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_have_pend <= n_have_pend;
            r_out       <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_idx   <= n_idx;
        r_slot  <= n_slot;
        r_e     <= n_e;
        r_start <= n_start;
        r_x     <= n_x;
        r_p     <= n_p;
        r_xr    <= n_xr;
        r_new   <= n_new;
        r_pend  <= n_pend;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `MSRT_ASSERT(a_idle_no_pend, i_clk, i_rst_n, o_in_ready |-> !r_have_pend)
    `MSRT_ASSERT(a_div_done_in_div, i_clk, i_rst_n, div_rsp.done |-> (r_state == S_TDIV))
    `MSRT_ASSERT(a_fin_sends_last, i_clk, i_rst_n, (r_state == S_FIN && out_free) |=> (o_out_valid && o_out_data.last))
    `MSRT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (o_in_ready && !o_out_valid))
endmodule
